@@ sv/cbm_pkg.sv @@
`timescale 1ns / 1ps
// cbm_pkg: types, decode constants and the pattern bank reset function
// shared by the bank mapper core, the config port and the top level.
package cbm_pkg;

  localparam logic       OP_WRITE = 1'b0;
  localparam logic       OP_TICK  = 1'b1;

  localparam logic [15:0] ADDR_MASK     = 16'hF800;
  localparam logic [15:0] ADDR_PATTERN0 = 16'h8800;
  localparam logic [15:0] ADDR_PATTERN1 = 16'h9800;
  localparam logic [15:0] ADDR_PATTERN2 = 16'hA800;
  localparam logic [15:0] ADDR_PATTERN3 = 16'hB800;
  localparam logic [15:0] ADDR_RELOAD   = 16'hC800;
  localparam logic [15:0] ADDR_IRQ_EN   = 16'hD800;
  localparam logic [15:0] ADDR_MIRROR   = 16'hE800;
  localparam logic [15:0] ADDR_PROGRAM  = 16'hF800;

  localparam int          IRQ_EN_BIT    = 4;
  localparam logic [7:0]  MIRROR_MASK   = 8'h03;
  localparam logic [7:0]  RELOAD_MATCH  = 8'hF6;
  localparam logic [8:0]  LAST_VISIBLE  = 9'd239;

  localparam logic [9:0]  CHR_COUNT_RESET = 10'd256;
  localparam logic        REG_CHR_COUNT   = 1'b0;

  typedef struct packed {
    logic       operation;
    logic [15:0] address;
    logic [7:0] write_data;
    logic [8:0] line_number;
    logic       rendering_on;
  } item_t;

  typedef struct packed {
    logic [3:0][7:0] pattern;
    logic [7:0]      prog;
    logic [1:0]      mirror;
    logic            irq;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [9:0] count;
  } cfg_write_t;

  function automatic logic [3:0][7:0] pattern_default(input logic [9:0] count);
    logic [7:0]      half;
    logic [3:0][7:0] banks;
    half     = count[8:1];
    banks[0] = 8'd0;
    banks[1] = 8'd1;
    banks[2] = half - 8'd2;
    banks[3] = half - 8'd1;
    return banks;
  endfunction

endpackage

@@ sv/cbm_apb.sv @@
`timescale 1ns / 1ps
// cbm_apb: APB-style config port holding the 1KB pattern bank count.
// Depends on cbm_pkg; emits a cfg_write_t toward the mapper core.
module cbm_apb import cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_write_t  cfg
);

  logic [9:0] chr_count;
  logic       wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_CHR_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_count <= CHR_COUNT_RESET;
    end else if (wr_hit) begin
      chr_count <= pwdata[9:0];
    end
  end

  assign cfg.en    = wr_hit;
  assign cfg.count = pwdata[9:0];

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_CHR_COUNT) begin
      prdata = {22'd0, chr_count};
    end
  end

endmodule

@@ sv/cbm_core.sv @@
`timescale 1ns / 1ps
// cbm_core: mapper state (banks, mirroring, IRQ counter and latch) and the
// single-pass update for one bus write or scanline tick. Depends on cbm_pkg.
module cbm_core import cbm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_write_t cfg,
  input  logic       fire,
  input  item_t      item,
  output result_t    result_next
);

  logic [3:0][7:0] pattern, pattern_next;
  logic [7:0]      prog_bank, prog_bank_next;
  logic [1:0]      mirror, mirror_next;
  logic            irq_en, irq_en_next;
  logic [7:0]      counter, counter_next;
  logic [7:0]      latch, latch_next;
  logic [7:0]      counter_dec;
  logic            irq_next;

  assign counter_dec = counter - 8'd1;

  always_comb begin
    pattern_next   = pattern;
    prog_bank_next = prog_bank;
    mirror_next    = mirror;
    irq_en_next    = irq_en;
    counter_next   = counter;
    latch_next     = latch;
    irq_next       = 1'b0;
    if (item.operation == OP_WRITE) begin
      case (item.address & ADDR_MASK)
        ADDR_PATTERN0: pattern_next[0] = item.write_data;
        ADDR_PATTERN1: pattern_next[1] = item.write_data;
        ADDR_PATTERN2: pattern_next[2] = item.write_data;
        ADDR_PATTERN3: pattern_next[3] = item.write_data;
        ADDR_RELOAD: begin
          counter_next = latch;
          latch_next   = item.write_data;
        end
        ADDR_IRQ_EN:  irq_en_next    = item.write_data[IRQ_EN_BIT];
        ADDR_MIRROR:  mirror_next    = item.write_data[1:0] & MIRROR_MASK[1:0];
        ADDR_PROGRAM: prog_bank_next = item.write_data;
        default: ;
      endcase
    end else if (irq_en && (item.line_number <= LAST_VISIBLE) && item.rendering_on) begin
      if (counter_dec == RELOAD_MATCH) begin
        counter_next = latch;
        irq_next     = 1'b1;
      end else begin
        counter_next = counter_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern   <= pattern_default(CHR_COUNT_RESET);
      prog_bank <= 8'd0;
      mirror    <= 2'd0;
      irq_en    <= 1'b0;
      counter   <= 8'd0;
      latch     <= 8'd0;
    end else if (cfg.en) begin
      pattern <= pattern_default(cfg.count);
    end else if (fire) begin
      pattern   <= pattern_next;
      prog_bank <= prog_bank_next;
      mirror    <= mirror_next;
      irq_en    <= irq_en_next;
      counter   <= counter_next;
      latch     <= latch_next;
    end
  end

  assign result_next.pattern = pattern_next;
  assign result_next.prog    = prog_bank_next;
  assign result_next.mirror  = mirror_next;
  assign result_next.irq     = irq_next;

endmodule

@@ sv/cartridge_bank_mapper_scanline_irq_unit.sv @@
`timescale 1ns / 1ps
// cartridge_bank_mapper_scanline_irq_unit: top level with input and result
// registers around cbm_core; config via cbm_apb. Depends on cbm_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one CPU bus write
//   (operation 0) or one end-of-scanline tick (operation 1) per transfer.
//   Output channel (out_valid/out_stall) returns one result per item: the
//   four 2KB pattern banks, the program bank and mirroring after the item,
//   plus irq_pulse set when a tick reloaded the counter.
//   The item passes the input register, then the result register; out_valid
//   rises as the result register is loaded, and the result transfers while
//   out_stall is low. Throughput: one item per cycle while out_stall is low,
//   set by the single-pass update in the core between those two registers.
//   When out_stall is high with a result held, the input register holds its
//   item and in_stall rises; one more item is still taken into the empty
//   input register.
//   Reset (rst, synchronous) clears both valid flags and loads the state
//   defaults: banks 0, 1, count/2-2, count/2-1 with count 256.
//   Writing the bank count over APB (address 0) also reloads the four
//   pattern banks; do it only while the block is idle.
module cartridge_bank_mapper_scanline_irq_unit import cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [8:0]  line_number,
  input  logic        rendering_on,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pattern_bank_0,
  output logic [7:0]  pattern_bank_1,
  output logic [7:0]  pattern_bank_2,
  output logic [7:0]  pattern_bank_3,
  output logic [7:0]  program_bank,
  output logic [1:0]  mirror_mode,
  output logic        irq_pulse,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_write_t cfg;
  item_t      item;
  logic       item_valid;
  result_t    result, result_next;
  logic       out_open;
  logic       fire;
  logic       in_take;

  assign out_open = !out_valid || !out_stall;
  assign fire     = item_valid && out_open;
  assign in_stall = item_valid && !out_open;
  assign in_take  = in_valid && !in_stall;

  cbm_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cbm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .fire        (fire),
    .item        (item),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.operation    <= operation;
      item.address      <= address;
      item.write_data   <= write_data;
      item.line_number  <= line_number;
      item.rendering_on <= rendering_on;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

  assign pattern_bank_0 = result.pattern[0];
  assign pattern_bank_1 = result.pattern[1];
  assign pattern_bank_2 = result.pattern[2];
  assign pattern_bank_3 = result.pattern[3];
  assign program_bank   = result.prog;
  assign mirror_mode    = result.mirror;
  assign irq_pulse      = result.irq;

endmodule
